// ===== sv/bdse_pkg.sv =====
// Shared types, constants and helper functions of the bouncing disc sprite engine.
package bdse_pkg;

  localparam int unsigned POS_W       = 15;
  localparam int unsigned VEL_W       = 11;
  localparam int unsigned RAD_W       = 3;
  localparam int unsigned COL_W       = 8;
  localparam int unsigned DT_W        = 16;
  localparam int unsigned BALL_W      = 3;
  localparam int unsigned SIZE_W      = 8;
  localparam int unsigned COORD_W     = 7;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned FRAC_W      = 8;
  localparam int unsigned DELTA_SHIFT = 12;
  localparam int unsigned PROD_W      = VEL_W + DT_W + 1;
  localparam int unsigned DELTA_W     = PROD_W - DELTA_SHIFT;
  localparam int unsigned SUM_W       = POS_W + 3;
  localparam int unsigned LIM_W       = SIZE_W + 2;
  localparam int unsigned ROW_DIFF_W  = COORD_W + 2;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_HEIGHT = CFG_IDX_W'(1);

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 8'd64;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 8'd32;
  localparam logic [SIZE_W-1:0] SIZE_LIMIT   = 8'd128;

  localparam logic signed [VEL_W-1:0] VEL_MIN = -11'sd1024;
  localparam logic signed [VEL_W-1:0] VEL_MAX = 11'sd1023;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_MOVE = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                     kind;
    logic [BALL_W-1:0]        ball;
    logic [POS_W-1:0]         pos_x;
    logic [POS_W-1:0]         pos_y;
    logic signed [VEL_W-1:0]  vel_x;
    logic signed [VEL_W-1:0]  vel_y;
    logic [RAD_W-1:0]         radius;
    logic [COL_W-1:0]         red;
    logic [COL_W-1:0]         green;
    logic [COL_W-1:0]         blue;
    logic [DT_W-1:0]          dt;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0]         pos_x;
    logic [POS_W-1:0]         pos_y;
    logic signed [VEL_W-1:0]  vel_x;
    logic signed [VEL_W-1:0]  vel_y;
    logic [RAD_W-1:0]         radius;
    logic [COL_W-1:0]         red;
    logic [COL_W-1:0]         green;
    logic [COL_W-1:0]         blue;
  } ball_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Negate a velocity; the most negative code saturates.
  function automatic logic signed [VEL_W-1:0] flip_vel(input logic signed [VEL_W-1:0] v);
    logic signed [VEL_W-1:0] n;
    n = -v;
    if (v == VEL_MIN) begin
      n = VEL_MAX;
    end
    return n;
  endfunction

  // Largest h with h*h + ady*ady <= r*r.
  function automatic logic [RAD_W-1:0] half_width(input logic [RAD_W-1:0] r,
                                                   input logic [RAD_W-1:0] ady);
    logic [RAD_W-1:0] hw;
    logic [7:0]       rr;
    logic [7:0]       lhs;
    hw = '0;
    rr = 8'(r) * 8'(r);
    for (int k = 0; k < (1 << RAD_W); k++) begin
      lhs = 8'(k * k) + 8'(ady) * 8'(ady);
      if ((k <= int'(r)) && (lhs <= rr)) begin
        hw = RAD_W'(k);
      end
    end
    return hw;
  endfunction

endpackage

// ===== sv/bdse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bdse_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bdse_front.sv =====
// Front end: accepts items, drops out-of-range balls and builds queue commands.
module bdse_front #(
  parameter int unsigned NUM_BALLS  = 8,
  parameter int unsigned MAX_RADIUS = 7
) (
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              op_i,
  input  logic [bdse_pkg::BALL_W-1:0]       ball_index_i,
  input  logic [bdse_pkg::POS_W-1:0]        load_x_i,
  input  logic [bdse_pkg::POS_W-1:0]        load_y_i,
  input  logic signed [bdse_pkg::VEL_W-1:0] load_vx_i,
  input  logic signed [bdse_pkg::VEL_W-1:0] load_vy_i,
  input  logic [bdse_pkg::RAD_W-1:0]        load_radius_i,
  input  logic [bdse_pkg::COL_W-1:0]        load_red_i,
  input  logic [bdse_pkg::COL_W-1:0]        load_green_i,
  input  logic [bdse_pkg::COL_W-1:0]        load_blue_i,
  input  logic [bdse_pkg::DT_W-1:0]         time_step_i,
  input  bdse_pkg::queue_status_t           queue_status_i,
  output logic                              push_o,
  output bdse_pkg::cmd_t                    cmd_o
);

  logic in_range;

  assign in_ready_o = !queue_status_i.full;
  assign in_range   = (int'(ball_index_i) < NUM_BALLS);
  assign push_o     = in_valid_i && in_ready_o && in_range;

  always_comb begin
    cmd_o.kind   = op_i ? bdse_pkg::CMD_MOVE : bdse_pkg::CMD_LOAD;
    cmd_o.ball   = ball_index_i;
    cmd_o.pos_x  = load_x_i;
    cmd_o.pos_y  = load_y_i;
    cmd_o.vel_x  = load_vx_i;
    cmd_o.vel_y  = load_vy_i;
    cmd_o.radius = (int'(load_radius_i) > MAX_RADIUS) ? bdse_pkg::RAD_W'(MAX_RADIUS)
                                                      : load_radius_i;
    cmd_o.red    = load_red_i;
    cmd_o.green  = load_green_i;
    cmd_o.blue   = load_blue_i;
    cmd_o.dt     = time_step_i;
  end

endmodule

// ===== sv/bdse_queue.sv =====
// Command queue between the front end and the back end.
module bdse_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  bdse_pkg::cmd_t          push_cmd_i,
  input  logic                    pop_i,
  output bdse_pkg::cmd_t          head_o,
  output bdse_pkg::queue_status_t status_o
);

  bdse_pkg::cmd_t                entry_q [bdse_pkg::QUEUE_DEPTH];
  logic [bdse_pkg::QPTR_W-1:0]   wr_ptr_q;
  logic [bdse_pkg::QPTR_W-1:0]   rd_ptr_q;
  logic [bdse_pkg::QCNT_W-1:0]   count_q;

  localparam logic [bdse_pkg::QPTR_W-1:0] PTR_LAST = bdse_pkg::QPTR_W'(bdse_pkg::QUEUE_DEPTH - 1);
  localparam logic [bdse_pkg::QCNT_W-1:0] CNT_FULL = bdse_pkg::QCNT_W'(bdse_pkg::QUEUE_DEPTH);

  assign status_o.full  = (count_q == CNT_FULL);
  assign status_o.empty = (count_q == '0);
  assign head_o         = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        entry_q[wr_ptr_q] <= push_cmd_i;
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== sv/bdse_back.sv =====
// Back end: ball table, motion update with wall reflection and span sequencer.
module bdse_back #(
  parameter int unsigned NUM_BALLS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  bdse_pkg::queue_status_t            queue_status_i,
  input  bdse_pkg::cmd_t                     queue_head_i,
  output logic                               queue_pop_o,
  input  logic [bdse_pkg::SIZE_W-1:0]        matrix_width_i,
  input  logic [bdse_pkg::SIZE_W-1:0]        matrix_height_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [bdse_pkg::COORD_W-1:0]       span_row_o,
  output logic [bdse_pkg::COORD_W-1:0]       span_x_first_o,
  output logic [bdse_pkg::COORD_W-1:0]       span_x_last_o,
  output logic [bdse_pkg::COL_W-1:0]         span_red_o,
  output logic [bdse_pkg::COL_W-1:0]         span_green_o,
  output logic [bdse_pkg::COL_W-1:0]         span_blue_o,
  output logic [bdse_pkg::BALL_W-1:0]        span_ball_o,
  output logic                               span_final_o
);

  localparam int unsigned IDX_W    = (NUM_BALLS > 1) ? $clog2(NUM_BALLS) : 1;
  localparam int unsigned BALL_BITS = $bits(bdse_pkg::ball_t);
  localparam int unsigned SW = bdse_pkg::SUM_W;
  localparam int unsigned CW = bdse_pkg::COORD_W;

  localparam logic signed [SW-1:0] P_ZERO = '0;
  localparam logic signed [SW-1:0] P_MAX  = SW'((1 << bdse_pkg::POS_W) - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_MOVE,
    ST_SPAN
  } state_e;

  state_e                               state_q;
  bdse_pkg::cmd_t                       cmd_q;
  bdse_pkg::ball_t                      ball_q;
  logic                                 axis_q;
  logic                                 rd_valid_q;
  logic [NUM_BALLS-1:0]                 valid_q;
  logic signed [bdse_pkg::PROD_W-1:0]   prod_q;
  logic [CW-1:0]                        row_q;
  logic [CW-1:0]                        row_last_q;
  logic                                 out_valid_q;
  logic [CW-1:0]                        span_row_q;
  logic [CW-1:0]                        span_x_first_q;
  logic [CW-1:0]                        span_x_last_q;
  logic                                 span_final_q;
  logic [bdse_pkg::COL_W-1:0]           span_red_q;
  logic [bdse_pkg::COL_W-1:0]           span_green_q;
  logic [bdse_pkg::COL_W-1:0]           span_blue_q;
  logic [bdse_pkg::BALL_W-1:0]          span_ball_q;

  // table port
  logic                                 ram_we;
  logic                                 ram_re;
  logic [IDX_W-1:0]                     ram_waddr;
  logic [IDX_W-1:0]                     head_idx;
  logic [IDX_W-1:0]                     cmd_idx;
  bdse_pkg::ball_t                      ram_wdata;
  bdse_pkg::ball_t                      ram_rdata;
  bdse_pkg::ball_t                      load_entry;
  logic [BALL_BITS-1:0]                 ram_rdata_raw;

  // motion
  logic [bdse_pkg::SIZE_W-1:0]          w_eff;
  logic [bdse_pkg::SIZE_W-1:0]          h_eff;
  logic [bdse_pkg::SIZE_W-1:0]          size_sel;
  logic [bdse_pkg::POS_W-1:0]           pos_sel;
  logic signed [bdse_pkg::VEL_W-1:0]    vel_sel;
  logic signed [bdse_pkg::PROD_W-1:0]   prod_d;
  logic signed [bdse_pkg::DELTA_W-1:0]  delta;
  logic signed [SW-1:0]                 p0;
  logic signed [SW-1:0]                 p1;
  logic signed [SW-1:0]                 p2;
  logic signed [SW-1:0]                 p3;
  logic signed [SW-1:0]                 p4;
  logic signed [SW-1:0]                 lim_lo;
  logic signed [SW-1:0]                 lim_hi;
  logic signed [bdse_pkg::LIM_W-1:0]    hi_int;
  logic signed [bdse_pkg::VEL_W-1:0]    v2;
  logic signed [bdse_pkg::VEL_W-1:0]    v3;
  logic [bdse_pkg::POS_W-1:0]           pos_new;
  bdse_pkg::ball_t                      ball_next;

  // span set-up and raster
  logic [bdse_pkg::RAD_W-1:0]           rad;
  logic [CW-1:0]                        cy_new;
  logic [CW-1:0]                        cx;
  logic [CW-1:0]                        cy;
  logic [CW-1:0]                        row_lo;
  logic [CW:0]                          row_top;
  logic [bdse_pkg::SIZE_W-1:0]          h_last;
  logic [bdse_pkg::SIZE_W-1:0]          w_last;
  logic [CW-1:0]                        row_hi;
  logic                                 visible;
  logic signed [bdse_pkg::ROW_DIFF_W-1:0] dy;
  logic [bdse_pkg::RAD_W-1:0]           ady;
  logic [bdse_pkg::RAD_W-1:0]           hw;
  logic [CW-1:0]                        x_first;
  logic [CW:0]                          x_right;
  logic [CW-1:0]                        x_last;
  logic                                 span_load;

  assign head_idx = IDX_W'(queue_head_i.ball);
  assign cmd_idx  = IDX_W'(cmd_q.ball);

  assign queue_pop_o = (state_q == ST_IDLE) && !queue_status_i.empty;

  always_comb begin
    load_entry.pos_x  = queue_head_i.pos_x;
    load_entry.pos_y  = queue_head_i.pos_y;
    load_entry.vel_x  = queue_head_i.vel_x;
    load_entry.vel_y  = queue_head_i.vel_y;
    load_entry.radius = queue_head_i.radius;
    load_entry.red    = queue_head_i.red;
    load_entry.green  = queue_head_i.green;
    load_entry.blue   = queue_head_i.blue;
  end

  assign ram_re    = queue_pop_o && (queue_head_i.kind == bdse_pkg::CMD_MOVE);
  assign ram_we    = (queue_pop_o && (queue_head_i.kind == bdse_pkg::CMD_LOAD)) ||
                     ((state_q == ST_MOVE) && axis_q);
  assign ram_waddr = (state_q == ST_IDLE) ? head_idx : cmd_idx;
  assign ram_wdata = (state_q == ST_IDLE) ? load_entry : ball_next;
  assign ram_rdata = bdse_pkg::ball_t'(ram_rdata_raw);

  bdse_ram #(
    .WIDTH (BALL_BITS),
    .DEPTH (NUM_BALLS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (BALL_BITS'(ram_wdata)),
    .re_i    (ram_re),
    .raddr_i (head_idx),
    .rdata_o (ram_rdata_raw)
  );

  // motion of one axis
  assign w_eff = (matrix_width_i > bdse_pkg::SIZE_LIMIT) ? bdse_pkg::SIZE_LIMIT
                                                         : matrix_width_i;
  assign h_eff = (matrix_height_i > bdse_pkg::SIZE_LIMIT) ? bdse_pkg::SIZE_LIMIT
                                                          : matrix_height_i;
  assign rad   = ball_q.radius;

  always_comb begin
    vel_sel  = axis_q ? ball_q.vel_y : ball_q.vel_x;
    pos_sel  = axis_q ? ball_q.pos_y : ball_q.pos_x;
    size_sel = axis_q ? h_eff : w_eff;
    prod_d   = vel_sel * $signed({1'b0, cmd_q.dt});
    delta    = $signed(prod_q[bdse_pkg::PROD_W-1:bdse_pkg::DELTA_SHIFT]);
    p0       = $signed({3'b000, pos_sel}) +
               $signed({{(SW - bdse_pkg::DELTA_W){delta[bdse_pkg::DELTA_W-1]}}, delta});
    p1       = (p0 < P_ZERO) ? P_ZERO : ((p0 > P_MAX) ? P_MAX : p0);
    lim_lo   = $signed({{(SW - bdse_pkg::RAD_W - bdse_pkg::FRAC_W){1'b0}}, rad,
                        {bdse_pkg::FRAC_W{1'b0}}});
    hi_int   = $signed({2'b00, size_sel}) - bdse_pkg::LIM_W'(1)
               - $signed({{(bdse_pkg::LIM_W - bdse_pkg::RAD_W){1'b0}}, rad});
    lim_hi   = $signed({hi_int, {bdse_pkg::FRAC_W{1'b0}}});
    p2       = p1;
    v2       = vel_sel;
    if (p1 < lim_lo) begin
      p2 = lim_lo;
      v2 = bdse_pkg::flip_vel(vel_sel);
    end
    p3 = p2;
    v3 = v2;
    if (p2 > lim_hi) begin
      p3 = lim_hi;
      v3 = bdse_pkg::flip_vel(v2);
    end
    p4      = (p3 < P_ZERO) ? P_ZERO : p3;
    pos_new = p4[bdse_pkg::POS_W-1:0];

    ball_next = ball_q;
    if (axis_q) begin
      ball_next.pos_y = pos_new;
      ball_next.vel_y = v3;
    end else begin
      ball_next.pos_x = pos_new;
      ball_next.vel_x = v3;
    end
  end

  // visible row range of the disc
  always_comb begin
    cy_new  = pos_new[bdse_pkg::POS_W-1:bdse_pkg::FRAC_W];
    row_lo  = (cy_new >= CW'(rad)) ? cy_new - CW'(rad) : '0;
    row_top = {1'b0, cy_new} + (CW + 1)'(rad);
    h_last  = h_eff - 1'b1;
    row_hi  = ((CW + 1)'(h_last) < row_top) ? h_last[CW-1:0] : row_top[CW-1:0];
    visible = (w_eff != '0) && (h_eff != '0);
  end

  // one span per cycle while the output is not stalled
  always_comb begin
    cx      = ball_q.pos_x[bdse_pkg::POS_W-1:bdse_pkg::FRAC_W];
    cy      = ball_q.pos_y[bdse_pkg::POS_W-1:bdse_pkg::FRAC_W];
    dy      = $signed({2'b00, row_q}) - $signed({2'b00, cy});
    ady     = dy[bdse_pkg::ROW_DIFF_W-1] ? bdse_pkg::RAD_W'(-dy) : bdse_pkg::RAD_W'(dy);
    hw      = bdse_pkg::half_width(rad, ady);
    x_first = (cx >= CW'(hw)) ? cx - CW'(hw) : '0;
    x_right = {1'b0, cx} + (CW + 1)'(hw);
    w_last  = w_eff - 1'b1;
    x_last  = ((CW + 1)'(w_last) < x_right) ? w_last[CW-1:0] : x_right[CW-1:0];
    span_load = (state_q == ST_SPAN) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cmd_q          <= '0;
      ball_q         <= '0;
      axis_q         <= 1'b0;
      rd_valid_q     <= 1'b0;
      valid_q        <= '0;
      prod_q         <= '0;
      row_q          <= '0;
      row_last_q     <= '0;
      out_valid_q    <= 1'b0;
      span_row_q     <= '0;
      span_x_first_q <= '0;
      span_x_last_q  <= '0;
      span_final_q   <= 1'b0;
      span_red_q     <= '0;
      span_green_q   <= '0;
      span_blue_q    <= '0;
      span_ball_q    <= '0;
    end else begin
      if (span_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (queue_pop_o) begin
            cmd_q <= queue_head_i;
            if (queue_head_i.kind == bdse_pkg::CMD_LOAD) begin
              valid_q[head_idx] <= 1'b1;
            end else begin
              rd_valid_q <= valid_q[head_idx];
              state_q    <= ST_READ;
            end
          end
        end
        ST_READ: begin
          ball_q  <= rd_valid_q ? ram_rdata : '0;
          axis_q  <= 1'b0;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          prod_q  <= prod_d;
          state_q <= ST_MOVE;
        end
        ST_MOVE: begin
          ball_q <= ball_next;
          if (!axis_q) begin
            axis_q  <= 1'b1;
            state_q <= ST_MUL;
          end else begin
            row_q      <= row_lo;
            row_last_q <= row_hi;
            state_q    <= visible ? ST_SPAN : ST_IDLE;
          end
        end
        ST_SPAN: begin
          if (span_load) begin
            span_row_q     <= row_q;
            span_x_first_q <= x_first;
            span_x_last_q  <= x_last;
            span_final_q   <= (row_q == row_last_q);
            span_red_q     <= ball_q.red;
            span_green_q   <= ball_q.green;
            span_blue_q    <= ball_q.blue;
            span_ball_q    <= cmd_q.ball;
            if (row_q == row_last_q) begin
              state_q <= ST_IDLE;
            end else begin
              row_q <= row_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign span_row_o     = span_row_q;
  assign span_x_first_o = span_x_first_q;
  assign span_x_last_o  = span_x_last_q;
  assign span_red_o     = span_red_q;
  assign span_green_o   = span_green_q;
  assign span_blue_o    = span_blue_q;
  assign span_ball_o    = span_ball_q;
  assign span_final_o   = span_final_q;

  a_no_port_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("table read and write in the same cycle");

  a_span_from_raster: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_SPAN))
    else $error("span item raised outside the raster state");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SPAN) |-> (row_q <= row_last_q))
    else $error("raster row past the last visible row");

  a_span_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (span_x_first_q <= span_x_last_q))
    else $error("span with first column right of last column");

  a_final_ends_disc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_load && (row_q == row_last_q) |=> (state_q == ST_IDLE))
    else $error("sequencer kept running after the final span");

endmodule

// ===== sv/bouncing_disc_sprite_engine_unit.sv =====
// Top level of the bouncing disc sprite engine: config registers, front end, queue, back end.
//
// A load item is written to the ball table in the same cycle it leaves the queue. An advance item
// leaves the queue, then takes its motion work (table read, then a multiply and a clamp step
// for each axis on one shared multiplier), then one span per visible disc row, 2*radius+1 at
// most, one per cycle while the output does not stall; each span is held in the output
// register until taken. A two-entry command queue lets the input side keep accepting while
// the back end works or the output stalls. The ball table resets by per-entry valid bits, so
// no clearing pass follows reset.
module bouncing_disc_sprite_engine_unit #(
  parameter int unsigned NUM_BALLS  = 8,
  parameter int unsigned MAX_RADIUS = 7
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [bdse_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [bdse_pkg::SIZE_W-1:0]            cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   op_i,
  input  logic [bdse_pkg::BALL_W-1:0]            ball_index_i,
  input  logic [bdse_pkg::POS_W-1:0]             load_x_i,
  input  logic [bdse_pkg::POS_W-1:0]             load_y_i,
  input  logic signed [bdse_pkg::VEL_W-1:0]      load_vx_i,
  input  logic signed [bdse_pkg::VEL_W-1:0]      load_vy_i,
  input  logic [bdse_pkg::RAD_W-1:0]             load_radius_i,
  input  logic [bdse_pkg::COL_W-1:0]             load_red_i,
  input  logic [bdse_pkg::COL_W-1:0]             load_green_i,
  input  logic [bdse_pkg::COL_W-1:0]             load_blue_i,
  input  logic [bdse_pkg::DT_W-1:0]              time_step_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [bdse_pkg::COORD_W-1:0]           span_row_o,
  output logic [bdse_pkg::COORD_W-1:0]           span_x_first_o,
  output logic [bdse_pkg::COORD_W-1:0]           span_x_last_o,
  output logic [bdse_pkg::COL_W-1:0]             span_red_o,
  output logic [bdse_pkg::COL_W-1:0]             span_green_o,
  output logic [bdse_pkg::COL_W-1:0]             span_blue_o,
  output logic [bdse_pkg::BALL_W-1:0]            span_ball_o,
  output logic                                   span_final_o
);

  logic [bdse_pkg::SIZE_W-1:0] matrix_width_q;
  logic [bdse_pkg::SIZE_W-1:0] matrix_height_q;
  logic                        push;
  logic                        pop;
  bdse_pkg::cmd_t              push_cmd;
  bdse_pkg::cmd_t              head_cmd;
  bdse_pkg::queue_status_t     queue_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_width_q  <= bdse_pkg::WIDTH_RESET;
      matrix_height_q <= bdse_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bdse_pkg::REG_MATRIX_WIDTH:  matrix_width_q  <= cfg_data_i;
        bdse_pkg::REG_MATRIX_HEIGHT: matrix_height_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  bdse_front #(
    .NUM_BALLS  (NUM_BALLS),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .ball_index_i   (ball_index_i),
    .load_x_i       (load_x_i),
    .load_y_i       (load_y_i),
    .load_vx_i      (load_vx_i),
    .load_vy_i      (load_vy_i),
    .load_radius_i  (load_radius_i),
    .load_red_i     (load_red_i),
    .load_green_i   (load_green_i),
    .load_blue_i    (load_blue_i),
    .time_step_i    (time_step_i),
    .queue_status_i (queue_status),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  bdse_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .status_o   (queue_status)
  );

  bdse_back #(
    .NUM_BALLS (NUM_BALLS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .queue_status_i  (queue_status),
    .queue_head_i    (head_cmd),
    .queue_pop_o     (pop),
    .matrix_width_i  (matrix_width_q),
    .matrix_height_i (matrix_height_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .span_row_o      (span_row_o),
    .span_x_first_o  (span_x_first_o),
    .span_x_last_o   (span_x_last_o),
    .span_red_o      (span_red_o),
    .span_green_o    (span_green_o),
    .span_blue_o     (span_blue_o),
    .span_ball_o     (span_ball_o),
    .span_final_o    (span_final_o)
  );

endmodule
